[design/qai_pkg.sv]
// qai_pkg: shared types, constants and the derivative term table
`default_nettype none
package qai_pkg;

	localparam logic signed [31:0] ATT_ONE    = 32'sh4000_0000;
	localparam logic [31:0]        STEP_RESET = 32'd42949673;
	localparam logic signed [31:0] Q_MAX      = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN      = 32'sh8000_0000;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_STEP_TIME  = 1'b0,
		REG_RATE_FRAME = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] rate_x;
		logic signed [31:0] rate_y;
		logic signed [31:0] rate_z;
	} rate_word_t;

	typedef struct packed {
		logic signed [31:0] att_w;
		logic signed [31:0] att_x;
		logic signed [31:0] att_y;
		logic signed [31:0] att_z;
	} att_word_t;

	typedef struct packed {
		cfg_reg_t    index;
		logic [31:0] value;
	} cfg_word_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_ACC,
		OP_SLO,
		OP_SHI,
		OP_SUM,
		OP_SQ,
		OP_SQEND,
		OP_SQRTI,
		OP_SQRT,
		OP_DIVI,
		OP_DIV,
		OP_WRITE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] idx;
	} cmd_t;

	// one product term of the quaternion derivative
	typedef struct packed {
		logic [1:0] comp;
		logic [1:0] att_sel;
		logic [1:0] rate_sel;
		logic       neg;
		logic       first;
		logic       last;
	} term_t;

	// body-frame term table; world frame flips the cross terms of d1..d3
	function automatic term_t term_sel(input logic [3:0] k, input logic frame);
		term_t t;
		t = '0;
		case (k)
			4'd0:  t = '{2'd0, 2'd1, 2'd0, 1'b1, 1'b1, 1'b0};
			4'd1:  t = '{2'd0, 2'd2, 2'd1, 1'b1, 1'b0, 1'b0};
			4'd2:  t = '{2'd0, 2'd3, 2'd2, 1'b1, 1'b0, 1'b1};
			4'd3:  t = '{2'd1, 2'd0, 2'd0, 1'b0, 1'b1, 1'b0};
			4'd4:  t = '{2'd1, 2'd3, 2'd1, 1'b0, 1'b0, 1'b0};
			4'd5:  t = '{2'd1, 2'd2, 2'd2, 1'b1, 1'b0, 1'b1};
			4'd6:  t = '{2'd2, 2'd3, 2'd0, 1'b1, 1'b1, 1'b0};
			4'd7:  t = '{2'd2, 2'd0, 2'd1, 1'b0, 1'b0, 1'b0};
			4'd8:  t = '{2'd2, 2'd1, 2'd2, 1'b0, 1'b0, 1'b1};
			4'd9:  t = '{2'd3, 2'd2, 2'd0, 1'b0, 1'b1, 1'b0};
			4'd10: t = '{2'd3, 2'd1, 2'd1, 1'b1, 1'b0, 1'b0};
			4'd11: t = '{2'd3, 2'd0, 2'd2, 1'b0, 1'b0, 1'b1};
			default: t = '0;
		endcase
		if (frame && (t.comp != 2'd0) && (t.att_sel != 2'd0)) begin
			t.neg = ~t.neg;
		end
		return t;
	endfunction

endpackage
`default_nettype wire

[design/qai_if.sv]
// qai_if: valid/ready channel interfaces for rates, attitude and configuration
`default_nettype none
interface qai_rate_if;
	logic                valid;
	logic                ready;
	qai_pkg::rate_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface qai_att_if;
	logic               valid;
	logic               ready;
	qai_pkg::att_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface qai_cfg_if;
	logic               valid;
	logic               ready;
	qai_pkg::cfg_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/qai_datapath.sv]
// qai_datapath: multiplier, accumulators, square root and four divider lanes
`default_nettype none
module qai_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire qai_pkg::cmd_t      cmd,
	input  wire qai_pkg::rate_word_t rate,
	qai_cfg_if.sink                 cfg,
	output qai_pkg::att_word_t      att_out
);
	import qai_pkg::*;

	logic [31:0]        step_q;
	logic               frame_q;
	logic signed [31:0] att_q [4];
	logic signed [31:0] rate_q [3];
	logic signed [63:0] prod_q;
	logic signed [65:0] acc_q;
	logic signed [38:0] d_q [4];
	logic signed [55:0] plo_q;
	logic signed [55:0] phi_q;
	logic signed [31:0] c_q [4];
	logic [63:0]        sq_q;
	logic [64:0]        tot_q;
	logic [63:0]        n_q;
	logic [63:0]        res_q;
	logic [62:0]        bit_q;
	logic [31:0]        mag_q;
	logic [31:0]        rem_q [4];
	logic [32:0]        nlo_q [4];
	logic [32:0]        quo_q [4];
	logic               ovf_q [4];
	att_word_t          out_q;

	term_t              term;
	logic [1:0]         ci;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] mul_ab;
	logic signed [63:0] tneg;
	logic signed [63:0] tsh;
	logic signed [65:0] sum66;
	logic signed [38:0] d_sel;
	logic signed [55:0] lo_prod;
	logic signed [55:0] hi_prod;
	logic signed [40:0] sum41;
	logic signed [31:0] sat_c;
	logic [31:0]        abs_sel;
	logic [63:0]        rb;
	logic [31:0]        abs_l [4];
	logic [32:0]        r2 [4];
	logic               ge [4];
	logic signed [31:0] fin [4];

	assign cfg.ready = 1'b1;
	assign att_out   = out_q;

	// operand selection and derivative product
	always_comb begin
		term  = term_sel(cmd.idx[3:0], frame_q);
		ci    = cmd.idx[1:0];
		mul_a = att_q[term.att_sel];
		case (term.rate_sel)
			2'd0:    mul_b = rate_q[0];
			2'd1:    mul_b = rate_q[1];
			default: mul_b = rate_q[2];
		endcase
		mul_ab = mul_a * mul_b;
		tneg   = term.neg ? -prod_q : prod_q;
		tsh    = tneg >>> 2;
		sum66  = (term.first ? 66'sd0 : acc_q) + {{2{tsh[63]}}, tsh};
	end

	// time step scaling and saturating add
	always_comb begin
		d_sel   = d_q[ci];
		lo_prod = d_sel * $signed({1'b0, step_q[15:0]});
		hi_prod = d_sel * $signed({1'b0, step_q[31:16]});
		sum41   = $signed({{9{att_q[ci][31]}}, att_q[ci]})
			+ $signed({phi_q[55], phi_q[55:16]});
		if (sum41 > $signed({{9{1'b0}}, Q_MAX})) begin
			sat_c = Q_MAX;
		end else if (sum41 < $signed({{9{1'b1}}, Q_MIN})) begin
			sat_c = Q_MIN;
		end else begin
			sat_c = sum41[31:0];
		end
		abs_sel = c_q[ci][31] ? 32'(-c_q[ci]) : 32'(c_q[ci]);
		rb      = res_q + {1'b0, bit_q};
	end

	// divider lanes and final saturation
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			abs_l[l] = c_q[l][31] ? 32'(-c_q[l]) : 32'(c_q[l]);
			r2[l]    = {rem_q[l], nlo_q[l][32]};
			ge[l]    = r2[l] >= {1'b0, mag_q};
			if (mag_q == 32'd0) begin
				fin[l] = c_q[l];
			end else if (c_q[l][31]) begin
				if (ovf_q[l] || (quo_q[l] > 33'h0_8000_0000)) begin
					fin[l] = Q_MIN;
				end else begin
					fin[l] = 32'(-quo_q[l]);
				end
			end else begin
				if (ovf_q[l] || (quo_q[l] > 33'h0_7FFF_FFFF)) begin
					fin[l] = Q_MAX;
				end else begin
					fin[l] = quo_q[l][31:0];
				end
			end
		end
	end

	// configuration registers and attitude state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_RESET;
			frame_q  <= 1'b0;
			att_q[0] <= ATT_ONE;
			att_q[1] <= '0;
			att_q[2] <= '0;
			att_q[3] <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.data.index)
					REG_STEP_TIME:  step_q  <= cfg.data.value;
					REG_RATE_FRAME: frame_q <= cfg.data.value[0];
					default: ;
				endcase
			end
			if (cmd.op == OP_WRITE) begin
				for (int l = 0; l < 4; l++) begin
					att_q[l] <= fin[l];
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				rate_q[0] <= rate.rate_x;
				rate_q[1] <= rate.rate_y;
				rate_q[2] <= rate.rate_z;
			end
			OP_MUL: begin
				prod_q <= mul_ab;
			end
			OP_ACC: begin
				acc_q <= sum66;
				if (term.last) begin
					d_q[term.comp] <= sum66[63:25];
				end
			end
			OP_SLO: begin
				plo_q <= lo_prod >>> 16;
			end
			OP_SHI: begin
				phi_q <= hi_prod + plo_q;
			end
			OP_SUM: begin
				c_q[ci] <= sat_c;
			end
			OP_SQ: begin
				sq_q  <= 64'(abs_sel) * 64'(abs_sel);
				tot_q <= (ci == 2'd0) ? 65'd0 : tot_q + {1'b0, sq_q};
			end
			OP_SQEND: begin
				tot_q <= tot_q + {1'b0, sq_q};
			end
			OP_SQRTI: begin
				n_q   <= {1'b0, tot_q[64:2]};
				res_q <= '0;
				bit_q <= 63'(1) << 62;
			end
			OP_SQRT: begin
				if (n_q >= rb) begin
					n_q   <= n_q - rb;
					res_q <= (res_q >> 1) + {1'b0, bit_q};
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_DIVI: begin
				mag_q <= res_q[31:0];
				for (int l = 0; l < 4; l++) begin
					rem_q[l] <= {4'd0, abs_l[l][31:4]};
					ovf_q[l] <= {4'd0, abs_l[l][31:4]} >= res_q[31:0];
					nlo_q[l] <= {abs_l[l][3:0], 29'd0};
					quo_q[l] <= '0;
				end
			end
			OP_DIV: begin
				for (int l = 0; l < 4; l++) begin
					rem_q[l] <= ge[l] ? 32'(r2[l] - {1'b0, mag_q}) : r2[l][31:0];
					quo_q[l] <= {quo_q[l][31:0], ge[l]};
					nlo_q[l] <= nlo_q[l] << 1;
				end
			end
			OP_WRITE: begin
				out_q.att_w <= fin[0];
				out_q.att_x <= fin[1];
				out_q.att_y <= fin[2];
				out_q.att_z <= fin[3];
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[design/qai_ctrl.sv]
// qai_ctrl: sequencer that steps the datapath through one attitude update
`default_nettype none
module qai_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          out_ready,
	output logic               out_valid,
	output qai_pkg::cmd_t      cmd
);
	import qai_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_ACC, S_SLO, S_SHI, S_SUM, S_SQ, S_SQEND,
		S_SQRTI, S_SQRT, S_DIVI, S_DIV, S_WB
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic       in_ready_q;
	logic       out_valid_q;
	logic       take;
	logic       go;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;
	assign take      = in_valid && in_ready_q;
	assign go        = !out_valid_q || out_ready;

	// command decode
	always_comb begin
		cmd.idx = cnt_q;
		case (state_q)
			S_IDLE:  cmd.op = take ? OP_LOAD : OP_NONE;
			S_MUL:   cmd.op = OP_MUL;
			S_ACC:   cmd.op = OP_ACC;
			S_SLO:   cmd.op = OP_SLO;
			S_SHI:   cmd.op = OP_SHI;
			S_SUM:   cmd.op = OP_SUM;
			S_SQ:    cmd.op = OP_SQ;
			S_SQEND: cmd.op = OP_SQEND;
			S_SQRTI: cmd.op = OP_SQRTI;
			S_SQRT:  cmd.op = OP_SQRT;
			S_DIVI:  cmd.op = OP_DIVI;
			S_DIV:   cmd.op = OP_DIV;
			S_WB:    cmd.op = go ? OP_WRITE : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	// state, counter and handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						in_ready_q <= 1'b0;
						cnt_q      <= '0;
						state_q    <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (cnt_q == 6'd11) begin
						cnt_q   <= '0;
						state_q <= S_SLO;
					end else begin
						cnt_q   <= cnt_q + 6'd1;
						state_q <= S_MUL;
					end
				end
				S_SLO: state_q <= S_SHI;
				S_SHI: state_q <= S_SUM;
				S_SUM: begin
					if (cnt_q == 6'd3) begin
						cnt_q   <= '0;
						state_q <= S_SQ;
					end else begin
						cnt_q   <= cnt_q + 6'd1;
						state_q <= S_SLO;
					end
				end
				S_SQ: begin
					if (cnt_q == 6'd3) begin
						cnt_q   <= '0;
						state_q <= S_SQEND;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_SQEND: state_q <= S_SQRTI;
				S_SQRTI: state_q <= S_SQRT;
				S_SQRT: begin
					if (cnt_q == 6'd31) begin
						cnt_q   <= '0;
						state_q <= S_DIVI;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_DIVI: state_q <= S_DIV;
				S_DIV: begin
					if (cnt_q == 6'd32) begin
						cnt_q   <= '0;
						state_q <= S_WB;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_WB: begin
					if (go) begin
						out_valid_q <= 1'b1;
						in_ready_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready_q |-> (state_q == S_IDLE))
		else $error("ready outside idle");
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !in_ready_q)
		else $error("ready after accept");
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_WRITE) |=> out_valid_q)
		else $error("result not presented");
	a_sqrt_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT) |-> (cnt_q <= 6'd31))
		else $error("square root count overrun");
`endif

endmodule
`default_nettype wire

[design/quaternion_attitude_integrator.sv]
// quaternion_attitude_integrator: top level joining controller and datapath
//
//  channel   dir  payload                          handshake
//  rate_in   in   rate_x, rate_y, rate_z           valid / ready
//  att_out   out  att_w, att_x, att_y, att_z       valid / ready
//  cfg       in   index, value                     valid / ready (always ready)
//
// one word runs through the 12 shared multiplies, the 32-step square root and
// the 33-step divider lanes between acceptance and result
// a new rate word is taken only after the previous update has been written back
// a result waits in its output register while the next word is worked on;
// a stalled output holds the update at write-back
// reset loads the identity attitude and the default step and frame
`default_nettype none
module quaternion_attitude_integrator (
	input  wire logic clk,
	input  wire logic arst_n,
	qai_rate_if.sink  rate_in,
	qai_att_if.source att_out,
	qai_cfg_if.sink   cfg
);
	import qai_pkg::*;

	cmd_t cmd;

	qai_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rate_in.valid),
		.in_ready  (rate_in.ready),
		.out_ready (att_out.ready),
		.out_valid (att_out.valid),
		.cmd       (cmd)
	);

	qai_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rate    (rate_in.data),
		.cfg     (cfg),
		.att_out (att_out.data)
	);

endmodule
`default_nettype wire
